/* rtl/core/sls_pkg.sv */
`timescale 1ns / 1ps
// sls_pkg: shared types and constants for the servo latch sequencer
// no dependencies; used by the interfaces, sls_cfg_regs, sls_ctrl and the top level

package sls_pkg;

  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned DELTA_W    = 9;
  localparam int unsigned TICKS_W    = 16;
  localparam int unsigned THRESH_W   = 9;
  localparam int unsigned RETRY_W    = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CURRENT_W  = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [PULSE_W-1:0]  OPEN_PULSE_RST  = 12'd2000;
  localparam logic [PULSE_W-1:0]  CLOSE_PULSE_RST = 12'd1000;
  localparam logic [DELTA_W-1:0]  DELTA_RST       = 9'd100;
  localparam logic [TICKS_W-1:0]  OVER_TICKS_RST  = 16'd300;
  localparam logic [TICKS_W-1:0]  CHECK_TICKS_RST = 16'd200;
  localparam logic [TICKS_W-1:0]  RETRY_TICKS_RST = 16'd300;
  localparam logic [THRESH_W-1:0] THRESH_RST      = 9'd100;
  localparam logic [RETRY_W-1:0]  MAX_RETRY_RST   = 4'd3;

  // pulse driven out of reset: close pulse minus delta
  localparam logic [PULSE_W-1:0]  DRIVEN_PULSE_RST = CLOSE_PULSE_RST - PULSE_W'(DELTA_RST);
  localparam logic [PULSE_W-1:0]  PULSE_FULL       = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_PULSE  = 3'd0,
    CFG_CLOSE_PULSE = 3'd1,
    CFG_DELTA       = 3'd2,
    CFG_OVER_TICKS  = 3'd3,
    CFG_CHECK_TICKS = 3'd4,
    CFG_RETRY_TICKS = 3'd5,
    CFG_THRESH      = 3'd6,
    CFG_MAX_RETRY   = 3'd7
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_OPEN    = 3'd1,
    KIND_CLOSE   = 3'd2,
    KIND_ENABLE  = 3'd3,
    KIND_DISABLE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    POS_OPENING = 2'd0,
    POS_OPEN    = 2'd1,
    POS_CLOSING = 2'd2,
    POS_CLOSED  = 2'd3
  } pos_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_CLOSE = 2'd1,
    FAULT_OPEN  = 2'd2
  } fault_e;

  typedef struct packed {
    logic [PULSE_W-1:0]  open_pulse_width;
    logic [PULSE_W-1:0]  close_pulse_width;
    logic [DELTA_W-1:0]  overdrive_delta;
    logic [TICKS_W-1:0]  overdrive_ticks;
    logic [TICKS_W-1:0]  check_delay_ticks;
    logic [TICKS_W-1:0]  retry_delay_ticks;
    logic [THRESH_W-1:0] stall_threshold;
    logic [RETRY_W-1:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_width;
    logic               servo_enable;
    pos_e               position_state;
    fault_e             fault;
  } res_t;

endpackage

/* rtl/core/sls_in_if.sv */
`timescale 1ns / 1ps
// sls_in_if: command/tick channel into the sequencer (valid/ready + payload)
// depends on sls_pkg for field widths

interface sls_in_if;
  logic                                valid;
  logic                                ready;
  logic [sls_pkg::KIND_W-1:0]          kind;
  logic signed [sls_pkg::CURRENT_W-1:0] current_sample;

  modport source (output valid, output kind, output current_sample, input ready);
  modport sink   (input valid, input kind, input current_sample, output ready);
endinterface

/* rtl/core/sls_out_if.sv */
`timescale 1ns / 1ps
// sls_out_if: result channel out of the sequencer (valid/ready + payload)
// depends on sls_pkg for field widths

interface sls_out_if;
  logic                        valid;
  logic                        ready;
  logic [sls_pkg::PULSE_W-1:0] pulse_width;
  logic                        servo_enable;
  logic [1:0]                  position_state;
  logic [1:0]                  fault;

  modport source (output valid, output pulse_width, output servo_enable,
                  output position_state, output fault, input ready);
  modport sink   (input valid, input pulse_width, input servo_enable,
                  input position_state, input fault, output ready);
endinterface

/* rtl/core/sls_cfg_regs.sv */
`timescale 1ns / 1ps
// sls_cfg_regs: configuration register file, pulse widths saturate on write
// depends on sls_pkg

module sls_cfg_regs #(
  parameter int unsigned PULSE_MIN = 500,
  parameter int unsigned PULSE_MAX = 2500
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sls_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sls_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output sls_pkg::cfg_t                  cfg_o
);

  localparam logic [sls_pkg::PULSE_W-1:0] PMIN = sls_pkg::PULSE_W'(PULSE_MIN);
  localparam logic [sls_pkg::PULSE_W-1:0] PMAX = sls_pkg::PULSE_W'(PULSE_MAX);

  sls_pkg::cfg_t                cfg_q;
  logic [sls_pkg::PULSE_W-1:0] wpulse;
  logic [sls_pkg::PULSE_W-1:0] pulse_sat;

  assign wpulse = cfg_wdata_i[sls_pkg::PULSE_W-1:0];

  always_comb begin
    priority if (wpulse < PMIN) begin
      pulse_sat = PMIN;
    end else if (wpulse > PMAX) begin
      pulse_sat = PMAX;
    end else begin
      pulse_sat = wpulse;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_pulse_width  <= sls_pkg::OPEN_PULSE_RST;
      cfg_q.close_pulse_width <= sls_pkg::CLOSE_PULSE_RST;
      cfg_q.overdrive_delta   <= sls_pkg::DELTA_RST;
      cfg_q.overdrive_ticks   <= sls_pkg::OVER_TICKS_RST;
      cfg_q.check_delay_ticks <= sls_pkg::CHECK_TICKS_RST;
      cfg_q.retry_delay_ticks <= sls_pkg::RETRY_TICKS_RST;
      cfg_q.stall_threshold   <= sls_pkg::THRESH_RST;
      cfg_q.max_retries       <= sls_pkg::MAX_RETRY_RST;
    end else if (cfg_we_i) begin
      unique case (sls_pkg::cfg_idx_e'(cfg_idx_i))
        sls_pkg::CFG_OPEN_PULSE:  cfg_q.open_pulse_width  <= pulse_sat;
        sls_pkg::CFG_CLOSE_PULSE: cfg_q.close_pulse_width <= pulse_sat;
        sls_pkg::CFG_DELTA:
          cfg_q.overdrive_delta <= cfg_wdata_i[sls_pkg::DELTA_W-1:0];
        sls_pkg::CFG_OVER_TICKS:  cfg_q.overdrive_ticks   <= cfg_wdata_i;
        sls_pkg::CFG_CHECK_TICKS: cfg_q.check_delay_ticks <= cfg_wdata_i;
        sls_pkg::CFG_RETRY_TICKS: cfg_q.retry_delay_ticks <= cfg_wdata_i;
        sls_pkg::CFG_THRESH:
          cfg_q.stall_threshold <= cfg_wdata_i[sls_pkg::THRESH_W-1:0];
        sls_pkg::CFG_MAX_RETRY:
          cfg_q.max_retries <= cfg_wdata_i[sls_pkg::RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/sls_ctrl.sv */
`timescale 1ns / 1ps
// sls_ctrl: latch phase sequencer; holds phase, wait timer, retry count and driven pulse
// depends on sls_pkg; the result for the current beat is combinational, registered by the top

module sls_ctrl #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  logic [sls_pkg::KIND_W-1:0]            kind_i,
  input  logic signed [sls_pkg::CURRENT_W-1:0]  current_sample_i,
  input  sls_pkg::cfg_t                         cfg_i,
  output sls_pkg::res_t                         res_o
);

  typedef enum logic [2:0] {
    PH_C_OVER  = 3'd0,
    PH_C_NORM  = 3'd1,
    PH_C_RETRY = 3'd2,
    PH_CLOSED  = 3'd3,
    PH_O_OVER  = 3'd4,
    PH_O_NORM  = 3'd5,
    PH_O_RETRY = 3'd6,
    PH_OPEN    = 3'd7
  } phase_e;

  localparam logic [TIMER_BITS-1:0] WAIT_RST = TIMER_BITS'(sls_pkg::OVER_TICKS_RST);

  phase_e                       phase_q, phase_d;
  logic [TIMER_BITS-1:0]        wait_q, wait_d, wait_dec;
  logic [sls_pkg::RETRY_W-1:0]  retry_q, retry_d;
  logic [sls_pkg::PULSE_W-1:0]  pulse_q, pulse_d;
  logic                         en_q, en_d;
  sls_pkg::fault_e              fault;
  sls_pkg::pos_e                pos;

  logic [sls_pkg::PULSE_W:0]    open_sum;
  logic [sls_pkg::PULSE_W-1:0]  open_od, close_od, delta_ext;
  logic [TIMER_BITS-1:0]        over_load, check_load, retry_load;
  logic                         due, stall;

  assign delta_ext = sls_pkg::PULSE_W'(cfg_i.overdrive_delta);
  assign open_sum  = {1'b0, cfg_i.open_pulse_width} + {1'b0, delta_ext};
  assign open_od   = open_sum[sls_pkg::PULSE_W] ? sls_pkg::PULSE_FULL
                                                : open_sum[sls_pkg::PULSE_W-1:0];
  assign close_od  = (cfg_i.close_pulse_width > delta_ext)
                   ? cfg_i.close_pulse_width - delta_ext : '0;

  assign over_load  = TIMER_BITS'(cfg_i.overdrive_ticks);
  assign check_load = TIMER_BITS'(cfg_i.check_delay_ticks);
  assign retry_load = TIMER_BITS'(cfg_i.retry_delay_ticks);

  assign wait_dec = (wait_q != '0) ? wait_q - TIMER_BITS'(1) : wait_q;
  assign due      = (wait_dec == '0);
  // negative readings never stall
  assign stall    = !current_sample_i[sls_pkg::CURRENT_W-1]
                  && (current_sample_i[sls_pkg::THRESH_W-1:0] >= cfg_i.stall_threshold);

  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    retry_d = retry_q;
    pulse_d = pulse_q;
    en_d    = en_q;
    fault   = sls_pkg::FAULT_NONE;
    if (step_i) begin
      unique case (sls_pkg::kind_e'(kind_i))
        sls_pkg::KIND_TICK: begin
          wait_d = wait_dec;
          unique case (phase_q)
            PH_C_OVER, PH_O_OVER: begin
              if (due) begin
                pulse_d = (phase_q == PH_C_OVER) ? cfg_i.close_pulse_width
                                                 : cfg_i.open_pulse_width;
                wait_d  = check_load;
                phase_d = (phase_q == PH_C_OVER) ? PH_C_NORM : PH_O_NORM;
              end
            end
            PH_C_NORM, PH_O_NORM: begin
              if (due) begin
                if (stall) begin
                  if (retry_q < cfg_i.max_retries) begin
                    // back off with the opposite nominal pulse
                    pulse_d = (phase_q == PH_C_NORM) ? cfg_i.open_pulse_width
                                                     : cfg_i.close_pulse_width;
                    wait_d  = retry_load;
                    phase_d = (phase_q == PH_C_NORM) ? PH_C_RETRY : PH_O_RETRY;
                    retry_d = retry_q + sls_pkg::RETRY_W'(1);
                  end else begin
                    // out of retries: reverse direction and flag it
                    wait_d  = over_load;
                    retry_d = '0;
                    if (phase_q == PH_C_NORM) begin
                      pulse_d = open_od;
                      phase_d = PH_O_OVER;
                      fault   = sls_pkg::FAULT_CLOSE;
                    end else begin
                      pulse_d = close_od;
                      phase_d = PH_C_OVER;
                      fault   = sls_pkg::FAULT_OPEN;
                    end
                  end
                end else begin
                  phase_d = (phase_q == PH_C_NORM) ? PH_CLOSED : PH_OPEN;
                  retry_d = '0;
                end
              end
            end
            PH_C_RETRY: begin
              if (due) begin
                pulse_d = close_od;
                wait_d  = over_load;
                phase_d = PH_C_OVER;
              end
            end
            PH_O_RETRY: begin
              if (due) begin
                pulse_d = open_od;
                wait_d  = over_load;
                phase_d = PH_O_OVER;
              end
            end
            PH_CLOSED: begin
              if (pulse_q != cfg_i.close_pulse_width) begin
                pulse_d = close_od;
                wait_d  = over_load;
                phase_d = PH_C_OVER;
              end
            end
            PH_OPEN: begin
              if (pulse_q != cfg_i.open_pulse_width) begin
                pulse_d = open_od;
                wait_d  = over_load;
                phase_d = PH_O_OVER;
              end
            end
            default: ;
          endcase
        end
        sls_pkg::KIND_OPEN: begin
          pulse_d = open_od;
          wait_d  = over_load;
          phase_d = PH_O_OVER;
        end
        sls_pkg::KIND_CLOSE: begin
          pulse_d = close_od;
          wait_d  = over_load;
          phase_d = PH_C_OVER;
        end
        sls_pkg::KIND_ENABLE:  en_d = 1'b1;
        sls_pkg::KIND_DISABLE: en_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (phase_d <= PH_C_RETRY) begin
      pos = sls_pkg::POS_CLOSING;
    end else if (phase_d == PH_CLOSED) begin
      pos = sls_pkg::POS_CLOSED;
    end else if (phase_d <= PH_O_RETRY) begin
      pos = sls_pkg::POS_OPENING;
    end else begin
      pos = sls_pkg::POS_OPEN;
    end
  end

  assign res_o.pulse_width    = pulse_d;
  assign res_o.servo_enable   = en_d;
  assign res_o.position_state = pos;
  assign res_o.fault          = fault;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_C_OVER;
      wait_q  <= WAIT_RST;
      retry_q <= '0;
      pulse_q <= sls_pkg::DRIVEN_PULSE_RST;
      en_q    <= 1'b1;
    end else begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      retry_q <= retry_d;
      pulse_q <= pulse_d;
      en_q    <= en_d;
    end
  end

  // a fault only comes out of a tick
  a_fault_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && fault != sls_pkg::FAULT_NONE) |-> (kind_i == sls_pkg::KIND_TICK))
    else $error("fault raised on a non-tick beat");

  // settled phases are only reached with a cleared retry count
  a_settled_no_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CLOSED || phase_q == PH_OPEN) |-> (retry_q == '0))
    else $error("settled phase with pending retries");

  // a back-off phase always carries at least one used retry
  a_retry_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_C_RETRY || phase_q == PH_O_RETRY) |-> (retry_q != '0))
    else $error("retry phase with zero retry count");

  // failing to close reverses into the open overdrive with retries reset
  a_close_fail_reverses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && fault == sls_pkg::FAULT_CLOSE) |=> (phase_q == PH_O_OVER && retry_q == '0))
    else $error("close failure did not reverse to open overdrive");

endmodule

/* rtl/core/servo_latch_sequencer.sv */
`timescale 1ns / 1ps
// servo_latch_sequencer: top level, input beat register, phase sequencer, result register
// depends on sls_pkg, sls_in_if, sls_out_if, sls_cfg_regs and sls_ctrl

// Every input beat (millisecond tick, open, close, enable or disable) produces exactly one
// result beat carrying the pulse width now driven, the enable, the position and a fault code
// that is set only on the beat where a close or open attempt runs out of retries. The block
// takes one beat per clock while the sink keeps ready high: a beat is captured in the input
// register, the sequencer updates its state and forms the result combinationally, and the
// result sits in the output register. Configuration writes take effect on the next clock and
// belong in idle periods.

module servo_latch_sequencer #(
  parameter int unsigned PULSE_MIN  = 500,
  parameter int unsigned PULSE_MAX  = 2500,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sls_in_if.sink                         in_if,
  sls_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [sls_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sls_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  sls_pkg::cfg_t                         cfg;
  sls_pkg::res_t                         res;
  sls_pkg::res_t                         out_q;
  logic                                  out_valid_q;
  logic                                  in_valid_q;
  logic [sls_pkg::KIND_W-1:0]            in_kind_q;
  logic signed [sls_pkg::CURRENT_W-1:0]  in_cur_q;
  logic                                  advance;

  // the held beat moves on whenever the output register is free or draining
  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_kind_q <= in_if.kind;
      in_cur_q  <= in_if.current_sample;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  sls_cfg_regs #(
    .PULSE_MIN (PULSE_MIN),
    .PULSE_MAX (PULSE_MAX)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sls_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .kind_i           (in_kind_q),
    .current_sample_i (in_cur_q),
    .cfg_i            (cfg),
    .res_o            (res)
  );

  assign out_if.valid          = out_valid_q;
  assign out_if.pulse_width    = out_q.pulse_width;
  assign out_if.servo_enable   = out_q.servo_enable;
  assign out_if.position_state = out_q.position_state;
  assign out_if.fault          = out_q.fault;

endmodule
